[rtl/core/assert_macros.svh]
// Assertion macros shared by the meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/srtcm_pkg.sv]
// Shared types and constants of the single-rate three-color meter.
package srtcm_pkg;

    localparam int TIME_WIDTH_DEF   = 48;
    localparam int BUCKET_WIDTH_DEF = 32;

    localparam int BYTES_WIDTH    = 16;
    localparam int STAMP_WIDTH    = 48;
    localparam int CFG_WIDTH      = 32;
    localparam int INDEX_WIDTH    = 2;
    localparam int PKT_BITS_WIDTH = BYTES_WIDTH + 3;

    // Tokens accrue per this many time units.
    localparam int RATE_PERIOD = 1000;
    localparam int REM_WIDTH   = 10;
    localparam int DIGIT_WIDTH = 4;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [CFG_WIDTH-1:0] RATE_RESET = 32'd1000;
    localparam logic [CFG_WIDTH-1:0] CBS_RESET  = 32'd12000;
    localparam logic [CFG_WIDTH-1:0] EBS_RESET  = 32'd12000;

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_RATE = 2'd0,
        REG_CBS  = 2'd1,
        REG_EBS  = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        MARK_GREEN  = 2'd0,
        MARK_YELLOW = 2'd1,
        MARK_RED    = 2'd2
    } color_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] rate;
        logic [CFG_WIDTH-1:0] cbs;
        logic [CFG_WIDTH-1:0] ebs;
    } cfg_t;

endpackage

[rtl/core/single_rate_three_color_meter.sv]
// Top level of the color-blind single-rate three-color meter.
//
// Usage: push a packet word (packet_bytes, arrival_time) while full is low;
// it is taken on a rising edge with push high and full low. Colors come out
// in arrival order on color while empty is low; take one with pop. One color
// per packet: green, yellow or red.
// Configuration: write rate, committed and excess bucket sizes through
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high. A size write
// refills both buckets through a registered fill flag. Write only while idle.
// Throughput: one packet per cycle unless the receiver stalls. The front end
// resolves the refill time in the accept cycle. The back end is a pipeline of
// one multiply stage, one sum stage, divide stages at four quotient bits
// each, (32 + min(TIME_WIDTH, BUCKET_WIDTH + 10) + 4) / 4 of them, and a
// bucket stage.
// Reset: rate 1000, bucket sizes 12000, both buckets full, refill time zero.
// Receiver stall: the output queue fills, the back pipe freezes, the middle
// queue fills and full rises; nothing is dropped.
module single_rate_three_color_meter import srtcm_pkg::*; #(
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int BUCKET_WIDTH = BUCKET_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // packet channel
    input  logic                   push,
    output logic                   full,
    input  logic [BYTES_WIDTH-1:0] packet_bytes,
    input  logic [STAMP_WIDTH-1:0] arrival_time,
    // color channel
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             color,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data
);

    localparam int MID_W = PKT_BITS_WIDTH + TIME_WIDTH;

    cfg_t cfg_reg, cfg_next;
    logic fill_reg, fill_next;
    logic cfg_write;

    logic                      accept;
    logic [PKT_BITS_WIDTH-1:0] front_bits;
    logic [TIME_WIDTH-1:0]     front_elapsed;

    logic [MID_W-1:0] mid_rdata;
    logic             mid_empty;
    logic             mid_pop;

    logic   out_push;
    logic   out_full;
    color_t out_color;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = push && !full;

    // Decode the register write; drop unknown indexes.
    always_comb
    begin
        cfg_next  = cfg_reg;
        fill_next = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RATE:
                begin
                    cfg_next.rate = cfg_data;
                end
                REG_CBS:
                begin
                    cfg_next.cbs = cfg_data;
                    fill_next    = 1'b1;
                end
                REG_EBS:
                begin
                    cfg_next.ebs = cfg_data;
                    fill_next    = 1'b1;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate <= RATE_RESET;
            cfg_reg.cbs  <= CBS_RESET;
            cfg_reg.ebs  <= EBS_RESET;
            fill_reg     <= 1'b0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            fill_reg <= fill_next;
        end
    end

    // Classify: elapsed time and refill decision at accept.
    srtcm_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .packet_bytes (packet_bytes),
        .arrival_time (arrival_time),
        .pkt_bits     (front_bits),
        .elapsed      (front_elapsed)
    );

    // Hold classified words between front and back.
    srtcm_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata ({front_bits, front_elapsed}),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    // Meter: token refill, buckets and color.
    srtcm_back #(
        .TIME_WIDTH   (TIME_WIDTH),
        .BUCKET_WIDTH (BUCKET_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fill       (fill_reg),
        .in_valid   (!mid_empty),
        .in_bits    (mid_rdata[MID_W-1:TIME_WIDTH]),
        .in_elapsed (mid_rdata[TIME_WIDTH-1:0]),
        .in_pop     (mid_pop),
        .out_push   (out_push),
        .out_color  (out_color),
        .out_full   (out_full)
    );

    // Park finished colors so the back end keeps going while the receiver waits.
    srtcm_fifo #(
        .WIDTH (2),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_color),
        .full  (out_full),
        .pop   (pop),
        .rdata (color),
        .empty (empty)
    );

endmodule

[rtl/core/srtcm_fifo.sv]
// Small register queue with push/full and pop/empty sides.
`include "assert_macros.svh"

module srtcm_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_CLK(a_fifo_bound, clk, rst_n, count_reg <= CW'(DEPTH), "queue count beyond depth")
    `ASSERT_NEXT(a_fifo_head_hold, clk, rst_n, !empty && !pop, $stable(rdata), "queue head moved without pop")

endmodule

[rtl/core/srtcm_front.sv]
// Front end: take a packet, work out elapsed time and move the refill time.
`include "assert_macros.svh"

module srtcm_front import srtcm_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      accept,
    input  logic [BYTES_WIDTH-1:0]    packet_bytes,
    input  logic [STAMP_WIDTH-1:0]    arrival_time,
    output logic [PKT_BITS_WIDTH-1:0] pkt_bits,
    output logic [TIME_WIDTH-1:0]     elapsed
);

    localparam int PROD_W = 2 * REM_WIDTH;

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] last_refill_reg, last_refill_next;
    logic [PROD_W-1:0]     small_prod;
    logic                  rate_big, elapsed_big, refill;

    if (TIME_WIDTH <= STAMP_WIDTH)
    begin : g_time_trim
        assign now = arrival_time[TIME_WIDTH-1:0];
    end
    else
    begin : g_time_wide
        assign now = {{(TIME_WIDTH - STAMP_WIDTH){1'b0}}, arrival_time};
    end

    assign pkt_bits = {packet_bytes, 3'b000};
    // Treat time running backwards as no time gone by.
    assign elapsed  = (now >= last_refill_reg) ? now - last_refill_reg : '0;

    // At least one token is due when rate * elapsed reaches one period.
    assign small_prod  = PROD_W'(cfg.rate[REM_WIDTH-1:0]) * PROD_W'(elapsed[REM_WIDTH-1:0]);
    assign rate_big    = cfg.rate >= CFG_WIDTH'(RATE_PERIOD);
    assign elapsed_big = elapsed >= TIME_WIDTH'(RATE_PERIOD);
    assign refill      = (cfg.rate != '0) && (elapsed != '0)
                         && (elapsed_big || rate_big || small_prod >= PROD_W'(RATE_PERIOD));

    assign last_refill_next = (accept && refill) ? now : last_refill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_refill_reg <= '0;
        end
        else
        begin
            last_refill_reg <= last_refill_next;
        end
    end

    `ASSERT_NEXT(a_refill_forward, clk, rst_n, 1'b1, last_refill_reg >= $past(last_refill_reg), "refill time moved backwards")

endmodule

[rtl/core/srtcm_back.sv]
// Back end: refill multiply, divide by the rate period, bucket update and color.
`include "assert_macros.svh"

module srtcm_back import srtcm_pkg::*; #(
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int BUCKET_WIDTH = BUCKET_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      fill,
    input  logic                      in_valid,
    input  logic [PKT_BITS_WIDTH-1:0] in_bits,
    input  logic [TIME_WIDTH-1:0]     in_elapsed,
    output logic                      in_pop,
    output logic                      out_push,
    output color_t                    out_color,
    input  logic                      out_full
);

    localparam int BW     = BUCKET_WIDTH;
    localparam int EW     = (TIME_WIDTH < BW + REM_WIDTH) ? TIME_WIDTH : BW + REM_WIDTH;
    localparam int CAP_W  = (TIME_WIDTH > BW + REM_WIDTH) ? TIME_WIDTH : BW + REM_WIDTH;
    localparam int EL     = (EW + 1) / 2;
    localparam int EH     = EW - EL;
    localparam int LW     = CFG_WIDTH + EL;
    localparam int HW     = CFG_WIDTH + EH;
    localparam int PW     = CFG_WIDTH + EW;
    localparam int ND     = (PW + DIGIT_WIDTH) / DIGIT_WIDTH;
    localparam int PD     = ND * DIGIT_WIDTH;
    localparam int CUR_W  = REM_WIDTH + DIGIT_WIDTH;
    localparam int NDIG   = (1 << DIGIT_WIDTH) - 1;
    localparam int SW     = (BW > CFG_WIDTH) ? BW : CFG_WIDTH;
    localparam int SUM1_W = BW + 1;
    localparam int SUM2_W = BW + 2;
    localparam int KW     = ((BW > PKT_BITS_WIDTH) ? BW : PKT_BITS_WIDTH) + 2;

    localparam logic [BW-1:0]    BMAX  = {BW{1'b1}};
    localparam logic [CAP_W-1:0] E_CAP = CAP_W'(RATE_PERIOD) << BW;

    logic adv;

    // Multiply stage
    logic                      a_valid_reg;
    logic [PKT_BITS_WIDTH-1:0] a_bits_reg;
    logic                      a_sat_reg;
    logic [LW-1:0]             a_pl_reg;
    logic [HW-1:0]             a_ph_reg;
    logic [CAP_W-1:0]          e_ext;
    logic [EW-1:0]             e_clip;

    // Sum stage
    logic                      b_valid_reg;
    logic [PKT_BITS_WIDTH-1:0] b_bits_reg;
    logic                      b_sat_reg;
    logic [PW-1:0]             b_p_reg;

    // Digit stages of the long division
    logic                      d_valid_reg [ND];
    logic [PKT_BITS_WIDTH-1:0] d_bits_reg  [ND];
    logic                      d_sat_reg   [ND];
    logic [PD-1:0]             d_w_reg     [ND];
    logic [REM_WIDTH-1:0]      d_rem_reg   [ND];
    logic [PD-1:0]             d_w_next    [ND];
    logic [REM_WIDTH-1:0]      d_rem_next  [ND];

    // Bucket stage
    logic                      s_valid_reg;
    logic [PKT_BITS_WIDTH-1:0] s_bits_reg;
    logic [BW-1:0]             s_add_reg;
    logic [PD-1:0]             quot;
    logic                      quot_over;

    logic [BW-1:0]     ct_reg, ct_next;
    logic [BW-1:0]     et_reg, et_next;
    logic [SW-1:0]     cbs_ext, ebs_ext;
    logic [BW-1:0]     cbs_c, ebs_c;
    logic [SUM1_W-1:0] tc;
    logic [SUM2_W-1:0] te;
    logic              spill;
    logic [BW-1:0]     ct_mid, et_mid;
    logic [KW-1:0]     bits_k;

    // Advance the whole pipe unless the finished word is blocked.
    assign adv      = !(s_valid_reg && out_full);
    assign in_pop   = adv && in_valid;
    assign out_push = s_valid_reg && !out_full;

    assign e_ext  = CAP_W'(in_elapsed);
    assign e_clip = in_elapsed[EW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_bits_reg <= in_bits;
            // Enough elapsed time saturates any nonzero rate.
            a_sat_reg  <= (e_ext >= E_CAP) && (cfg.rate != '0);
            a_pl_reg   <= LW'(cfg.rate) * LW'(e_clip[EL-1:0]);
            a_ph_reg   <= HW'(cfg.rate) * HW'(e_clip[EW-1:EL]);
            b_bits_reg <= a_bits_reg;
            b_sat_reg  <= a_sat_reg;
            b_p_reg    <= PW'(a_pl_reg) + (PW'(a_ph_reg) << EL);
        end
    end

    always_comb
    begin
        logic [PD-1:0]          w_in;
        logic [REM_WIDTH-1:0]   rem_in;
        logic [CUR_W-1:0]       cur;
        logic [DIGIT_WIDTH-1:0] dig;
        for (int j = 0; j < ND; j++)
        begin
            if (j == 0)
            begin
                w_in   = PD'(b_p_reg);
                rem_in = '0;
            end
            else
            begin
                w_in   = d_w_reg[j-1];
                rem_in = d_rem_reg[j-1];
            end
            cur = {rem_in, w_in[PD-1 -: DIGIT_WIDTH]};
            dig = '0;
            for (int k = 1; k <= NDIG; k++)
            begin
                if (cur >= CUR_W'(k * RATE_PERIOD))
                begin
                    dig = DIGIT_WIDTH'(k);
                end
            end
            // Shift the dividend out at the top and the quotient digit in below.
            d_w_next[j]   = {w_in[PD-DIGIT_WIDTH-1:0], dig};
            d_rem_next[j] = REM_WIDTH'(cur - CUR_W'(dig) * CUR_W'(RATE_PERIOD));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < ND; j++)
            begin
                d_w_reg[j]   <= d_w_next[j];
                d_rem_reg[j] <= d_rem_next[j];
                d_bits_reg[j] <= (j == 0) ? b_bits_reg : d_bits_reg[j-1];
                d_sat_reg[j]  <= (j == 0) ? b_sat_reg : d_sat_reg[j-1];
            end
        end
    end

    assign quot      = d_w_reg[ND-1];
    assign quot_over = |quot[PD-1:BW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_bits_reg <= d_bits_reg[ND-1];
            s_add_reg  <= (d_sat_reg[ND-1] || quot_over) ? BMAX : quot[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            for (int j = 0; j < ND; j++)
            begin
                d_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            s_valid_reg <= d_valid_reg[ND-1];
            for (int j = 0; j < ND; j++)
            begin
                d_valid_reg[j] <= (j == 0) ? b_valid_reg : d_valid_reg[j-1];
            end
        end
    end

    // Clip bucket sizes to the token width.
    assign cbs_ext = SW'(cfg.cbs);
    assign ebs_ext = SW'(cfg.ebs);
    assign cbs_c   = (cbs_ext > SW'(BMAX)) ? BMAX : cbs_ext[BW-1:0];
    assign ebs_c   = (ebs_ext > SW'(BMAX)) ? BMAX : ebs_ext[BW-1:0];

    assign tc     = SUM1_W'(ct_reg) + SUM1_W'(s_add_reg);
    assign spill  = tc > SUM1_W'(cbs_c);
    assign te     = SUM2_W'(et_reg) + SUM2_W'(tc - SUM1_W'(cbs_c));
    assign ct_mid = spill ? cbs_c : tc[BW-1:0];
    assign et_mid = spill ? ((te > SUM2_W'(ebs_c)) ? ebs_c : te[BW-1:0]) : et_reg;
    assign bits_k = KW'(s_bits_reg);

    always_comb
    begin
        ct_next   = ct_reg;
        et_next   = et_reg;
        out_color = MARK_RED;
        if (bits_k <= KW'(ct_mid))
        begin
            out_color = MARK_GREEN;
        end
        else if (bits_k <= KW'(et_mid))
        begin
            out_color = MARK_YELLOW;
        end
        priority if (fill)
        begin
            ct_next = cbs_c;
            et_next = ebs_c;
        end
        else if (out_push)
        begin
            ct_next = ct_mid;
            et_next = et_mid;
            if (out_color == MARK_GREEN)
            begin
                ct_next = BW'(KW'(ct_mid) - bits_k);
            end
            else if (out_color == MARK_YELLOW)
            begin
                et_next = BW'(KW'(et_mid) - bits_k);
            end
        end
        else
        begin
            ct_next = ct_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct_reg <= BW'(CBS_RESET);
            et_reg <= BW'(EBS_RESET);
        end
        else
        begin
            ct_reg <= ct_next;
            et_reg <= et_next;
        end
    end

    `ASSERT_NEXT(a_stall_hold, clk, rst_n, s_valid_reg && out_full, s_valid_reg && $stable(s_add_reg) && $stable(s_bits_reg), "blocked word changed while stalled")

endmodule

[sim/single_rate_three_color_meter_tb.sv]
// Self-checking testbench of the color-blind single-rate three-color meter.
module single_rate_three_color_meter_tb;
    import srtcm_pkg::*;

    // Accept-to-color latency at default widths, used to size the final drain wait.
    localparam int LATENCY         = 23;
    localparam int CYCLE_LIMIT     = 400_000;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 220;
    localparam int CALM_PHASE      = 3;
    localparam int HOLD_PHASE      = 4;
    localparam int HOLD_CYCLES     = 400;
    localparam int IDLE_PERCENT    = 34;
    localparam int REPORT_LIMIT    = 10;
    localparam int SCRIPT_ROWS     = 32;

    localparam logic [63:0]            BUCKET_FULL = (64'd1 << BUCKET_WIDTH_DEF) - 64'd1;
    // No register sits at this index; a write there must leave the meter untouched.
    localparam logic [INDEX_WIDTH-1:0] REG_SPARE   = 2'd3;

    typedef enum logic {
        ROW_PACKET,
        ROW_WRITE
    } row_kind_t;

    // One line of the directed script: either a packet word or a register write.
    // Where typed is set, want is the color read straight off the bucket math.
    typedef struct packed {
        row_kind_t                kind;
        logic [BYTES_WIDTH-1:0]   nbytes;
        logic [STAMP_WIDTH-1:0]   stamp;
        logic [INDEX_WIDTH-1:0]   reg_idx;
        logic [CFG_WIDTH-1:0]     wdata;
        logic                     typed;
        color_t                   want;
    } row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   push         = 1'b0;
    logic                   full;
    logic [BYTES_WIDTH-1:0] packet_bytes = '0;
    logic [STAMP_WIDTH-1:0] arrival_time = '0;
    logic                   empty;
    logic                   pop          = 1'b0;
    logic [1:0]             color;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [INDEX_WIDTH-1:0] cfg_index    = '0;
    logic [CFG_WIDTH-1:0]   cfg_data     = '0;

    // Shadow of the meter: configuration, both buckets and the refill stamp.
    logic [CFG_WIDTH-1:0]   cir          = RATE_RESET;
    logic [CFG_WIDTH-1:0]   cbs          = CBS_RESET;
    logic [CFG_WIDTH-1:0]   ebs          = EBS_RESET;
    logic [63:0]            green_tokens = 64'(CBS_RESET);
    logic [63:0]            amber_tokens = 64'(EBS_RESET);
    logic [STAMP_WIDTH-1:0] refill_stamp = '0;

    color_t expected_colors[$];
    int     failures      = 0;
    int     cycle_count   = 0;
    bit     calm_stretch  = 1'b0;
    bit     hold_request  = 1'b0;

    // Directed script. Rows walk through: colors straight after reset, a refill
    // too small to move the stamp, zero rate, the widest arrival time, time going
    // backwards, the widest sizes, a saturating refill, empty buckets, a write to
    // an index with no register, and back to the reset settings.
    row_t script [SCRIPT_ROWS] = '{
        '{ROW_PACKET, 16'd1500,  48'd0,               REG_RATE,  32'd0,  1'b1, MARK_GREEN},
        '{ROW_PACKET, 16'd1500,  48'd0,               REG_RATE,  32'd0,  1'b1, MARK_YELLOW},
        '{ROW_PACKET, 16'd0,     48'd0,               REG_RATE,  32'd0,  1'b1, MARK_GREEN},
        '{ROW_PACKET, 16'd1,     48'd0,               REG_RATE,  32'd0,  1'b1, MARK_RED},
        '{ROW_PACKET, 16'd65535, 48'd0,               REG_RATE,  32'd0,  1'b1, MARK_RED},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_RATE,  32'd3,  1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd1,     48'd100,             REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd1,     48'd300,             REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd1,     48'd400,             REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd1,     48'd3000,            REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd0,     48'hFFFF_FFFF_FFFF,  REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd1,     48'hFFFF_FFFF_FFFF,  REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_RATE,  32'd1000, 1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd1,     48'd1000,            REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_CBS,   32'hFFFF_FFFF, 1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd65535, 48'd2000,            REG_RATE,  32'd0,  1'b1, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_EBS,   32'd0,  1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd65535, 48'd3000,            REG_RATE,  32'd0,  1'b1, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_RATE,  32'hFFFF_FFFF, 1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd1500,  48'h0100_0000_0000,  REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_CBS,   32'd0,  1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd0,     48'h0100_0000_0000,  REG_RATE,  32'd0,  1'b1, MARK_GREEN},
        '{ROW_PACKET, 16'd1,     48'h0100_0000_0001,  REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_EBS,   32'hFFFF_FFFF, 1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd65535, 48'h0100_0000_0001,  REG_RATE,  32'd0,  1'b1, MARK_YELLOW},
        '{ROW_PACKET, 16'd65535, 48'h0100_0000_0002,  REG_RATE,  32'd0,  1'b0, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_SPARE, 32'd0,  1'b0, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_RATE,  32'd1000, 1'b0, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_CBS,   32'd12000, 1'b0, MARK_GREEN},
        '{ROW_WRITE,  16'd0,     48'd0,               REG_EBS,   32'd12000, 1'b0, MARK_GREEN},
        '{ROW_PACKET, 16'd1500,  48'h0100_0000_2EE0,  REG_RATE,  32'd0,  1'b0, MARK_GREEN}
    };

    single_rate_three_color_meter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .packet_bytes (packet_bytes),
        .arrival_time (arrival_time),
        .empty        (empty),
        .pop          (pop),
        .color        (color),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Meter one packet against the shadow buckets and return its color.
    // Sizes are as wide as the buckets here, so no size ever needs clipping.
    function automatic color_t meter_packet(input logic [BYTES_WIDTH-1:0] nbytes,
                                            input logic [STAMP_WIDTH-1:0] stamp);
        logic [63:0] need;
        logic [63:0] elapsed;
        logic [63:0] periods;
        logic [63:0] leftover;
        logic [63:0] credit;
        logic [63:0] fill;
        color_t      hue;
        need     = 64'(nbytes) * 64'd8;
        elapsed  = (stamp >= refill_stamp) ? 64'(stamp - refill_stamp) : 64'd0;
        periods  = elapsed / 64'(RATE_PERIOD);
        leftover = elapsed % 64'(RATE_PERIOD);
        // floor(rate * elapsed / period), built in two parts so nothing overflows
        if (cir == '0)
            credit = 64'd0;
        else if (periods > BUCKET_FULL / 64'(cir))
            credit = BUCKET_FULL;
        else
        begin
            credit = periods * 64'(cir) + (64'(cir) * leftover) / 64'(RATE_PERIOD);
            if (credit > BUCKET_FULL)
                credit = BUCKET_FULL;
        end
        // Hold the stamp when no whole token came in, so the fraction keeps building.
        if (credit != 64'd0)
            refill_stamp = stamp;
        fill = green_tokens + credit;
        if (fill > 64'(cbs))
        begin
            amber_tokens = amber_tokens + (fill - 64'(cbs));
            if (amber_tokens > 64'(ebs))
                amber_tokens = 64'(ebs);
            fill = 64'(cbs);
        end
        green_tokens = fill;
        if (need <= green_tokens)
        begin
            green_tokens = green_tokens - need;
            hue = MARK_GREEN;
        end
        else if (need <= amber_tokens)
        begin
            amber_tokens = amber_tokens - need;
            hue = MARK_YELLOW;
        end
        else
            hue = MARK_RED;
        return hue;
    endfunction

    function automatic void note_failure(input string what, input int want, input int got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0d] %s: expected %0d, got %0d", cycle_count, what, want, got);
    endfunction

    // Offer one packet word, holding push high until it is taken. Leave push high
    // afterwards so back-to-back words never lower and raise it in one step.
    task automatic send_packet(input logic [BYTES_WIDTH-1:0] nbytes,
                               input logic [STAMP_WIDTH-1:0] stamp,
                               input logic typed, input color_t want);
        color_t hue;
        while (!calm_stretch && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        packet_bytes <= nbytes;
        arrival_time <= stamp;
        do
            @(posedge clk);
        while (full);
        hue = meter_packet(nbytes, stamp);
        expected_colors.push_back(typed ? want : hue);
    endtask

    // Drop push and wait until every color owed has been popped.
    task automatic settle_meter();
        push <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
    endtask

    // Write one register, then wait for the block to refill its buckets.
    task automatic write_register(input logic [INDEX_WIDTH-1:0] idx,
                                  input logic [CFG_WIDTH-1:0] wdata);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= wdata;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RATE: cir = wdata;
            REG_CBS:  cbs = wdata;
            REG_EBS:  ebs = wdata;
            default:  ;
        endcase
        // Any size write fills both buckets; the refill stamp stays.
        if (idx == REG_CBS || idx == REG_EBS)
        begin
            green_tokens = 64'(cbs);
            amber_tokens = 64'(ebs);
        end
        @(posedge clk);
    endtask

    // Color checker: compare each popped word with the oldest color owed.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_colors.size() == 0)
                note_failure("color with no packet pending", -1, int'(color));
            else if (color !== expected_colors[0])
            begin
                note_failure("color mismatch", int'(expected_colors[0]), int'(color));
                void'(expected_colors.pop_front());
            end
            else
                void'(expected_colors.pop_front());
        end
    end

    // Watchdog: end the run as failed once the cycle count reaches its limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: pop at random, never idle during the calm stretch, and once hold
    // off long enough for the output and middle queues to fill and full to rise.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            pop <= calm_stretch || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    // Stimulus: reset, directed script, then random phases over several settings.
    initial
    begin
        int                     phase;
        logic [STAMP_WIDTH-1:0] stamp_clock;
        logic [STAMP_WIDTH-1:0] stamp;
        logic [BYTES_WIDTH-1:0] nbytes;
        logic [CFG_WIDTH-1:0]   rate_pick;
        logic [CFG_WIDTH-1:0]   cbs_pick;
        logic [CFG_WIDTH-1:0]   ebs_pick;
        logic [63:0]            span;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                settle_meter();
                write_register(script[i].reg_idx, script[i].wdata);
            end
            else
                send_packet(script[i].nbytes, script[i].stamp, script[i].typed, script[i].want);
        end

        // Advance a running clock past the last directed stamp.
        stamp_clock = 48'h0100_0001_0000;
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    rate_pick = RATE_RESET;
                    cbs_pick  = CBS_RESET;
                    ebs_pick  = EBS_RESET;
                end
                1:
                begin
                    rate_pick = 32'd1;
                    cbs_pick  = 32'd0;
                    ebs_pick  = 32'd0;
                end
                2:
                begin
                    rate_pick = 32'hFFFF_FFFF;
                    cbs_pick  = 32'hFFFF_FFFF;
                    ebs_pick  = 32'hFFFF_FFFF;
                end
                default:
                begin
                    rate_pick = $urandom_range(100, 2_000_000);
                    cbs_pick  = $urandom_range(0, 400_000);
                    ebs_pick  = $urandom_range(0, 400_000);
                end
            endcase
            settle_meter();
            write_register(REG_RATE, rate_pick);
            write_register(REG_CBS, cbs_pick);
            write_register(REG_EBS, ebs_pick);
            calm_stretch = (phase == CALM_PHASE);
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;

            // Jump the clock now and then; push it near the top in the last
            // phase so the high stamp bits toggle too.
            if (phase == PHASES - 1)
                stamp_clock = 48'hF000_0000_0000 | 48'($urandom);
            else if ($urandom_range(0, 3) == 0)
                stamp_clock = stamp_clock + (48'($urandom) << $urandom_range(0, 12));

            // Size the time steps so refill roughly matches what the packets drain.
            span = 64'd16_000_000 / 64'(cir);
            if (span > 64'd1_000_000)
                span = 64'd1_000_000;
            if (span == 64'd0)
                span = 64'd1;

            repeat (WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                    nbytes = 16'($urandom);
                else
                    nbytes = 16'($urandom_range(0, 2000));
                // Mostly in-order stamps; now and then one from the past.
                if ($urandom_range(0, 19) == 0)
                    stamp = 48'({$urandom, $urandom} % (64'(stamp_clock) + 64'd1));
                else
                begin
                    stamp_clock = stamp_clock + 48'($urandom_range(0, 32'(span)));
                    stamp = stamp_clock;
                end
                send_packet(nbytes, stamp, 1'b0, MARK_GREEN);
            end
        end
        calm_stretch = 1'b0;

        // Drain, then give stray colors time to show up.
        settle_meter();
        repeat (2 * LATENCY) @(posedge clk);
        if (expected_colors.size() != 0)
            note_failure("colors never delivered", 0, expected_colors.size());

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/srtcm_pkg.sv
rtl/core/srtcm_fifo.sv
rtl/core/srtcm_front.sv
rtl/core/srtcm_back.sv
rtl/core/single_rate_three_color_meter.sv
sim/single_rate_three_color_meter_tb.sv
